// ===== rtl/bf3h_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, payload types and states of the three-hash bloom filter
package bf3h_pkg;

	// filter store geometry
	localparam int MAX_BITS = 1024;
	localparam int IDX_W    = $clog2(MAX_BITS);
	localparam int M_W      = IDX_W + 1;

	// field and register widths
	localparam int FB_W      = 11;
	localparam int HC_W      = 4;
	localparam int CHAR_W    = 8;
	localparam int HASH_W    = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 11;

	// register reset values
	localparam logic [FB_W-1:0] FB_RESET = FB_W'(100);
	localparam logic [HC_W-1:0] HC_RESET = HC_W'(3);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = CFG_IDX_W'(1);

	// op codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	// remainder unit: one digit of the hash per cycle
	localparam int NUM_HASH  = 3;
	localparam int HSEL_W    = 2;
	localparam int DIGIT_W   = 8;
	localparam int DIGITS    = HASH_W / DIGIT_W;
	localparam int DIG_CNT_W = $clog2(DIGITS);

	// job queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// input transaction
	typedef struct packed {
		logic                     op;
		logic signed [CHAR_W-1:0] key_char;
		logic                     key_last;
	} in_item_t;

	// output transaction
	typedef struct packed {
		logic done_op;
		logic found;
	} out_item_t;

	// finished key handed from front to back
	typedef struct packed {
		logic              op;
		logic [HASH_W-1:0] h_mul31;
		logic [HASH_W-1:0] h_rotadd;
		logic [HASH_W-1:0] h_mul17;
	} job_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_PROBE,
		ST_WAIT,
		ST_DONE
	} back_state_t;

endpackage

// ===== rtl/bf3h_ram.sv =====
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module bf3h_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/bf3h_front.sv =====
`timescale 1ns / 1ps
// front end: takes key characters, runs the three hashes, emits finished keys
module bf3h_front import bf3h_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  logic     clearing,
	input  logic     q_full,
	output logic     push,
	output job_t     push_data
);

	logic [HASH_W-1:0] h_mul31_q;
	logic [HASH_W-1:0] h_rotadd_q;
	logic [HASH_W-1:0] h_mul17_q;
	logic [HASH_W-1:0] char_x;
	logic [HASH_W-1:0] n_mul31;
	logic [HASH_W-1:0] n_rotadd;
	logic [HASH_W-1:0] n_mul17;
	logic              accept;

	// hold off characters while the store clears or the queue is full
	assign in_stall = clearing | q_full;
	assign accept   = in_valid & ~in_stall;

	// next hash values, character sign-extended
	always_comb begin
		char_x   = HASH_W'(signed'(in_data.key_char));
		n_mul31  = (h_mul31_q << 5) - h_mul31_q + char_x;
		n_rotadd = (h_rotadd_q << 5) + (h_rotadd_q >> 27) + char_x;
		n_mul17  = (h_mul17_q << 4) + h_mul17_q + char_x;
	end

	// finished key goes to the queue
	assign push               = accept & in_data.key_last;
	assign push_data.op       = in_data.op;
	assign push_data.h_mul31  = n_mul31;
	assign push_data.h_rotadd = n_rotadd;
	assign push_data.h_mul17  = n_mul17;

	// running hashes, back to zero after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_mul31_q  <= '0;
			h_rotadd_q <= '0;
			h_mul17_q  <= '0;
		end else if (accept) begin
			if (in_data.key_last) begin
				h_mul31_q  <= '0;
				h_rotadd_q <= '0;
				h_mul17_q  <= '0;
			end else begin
				h_mul31_q  <= n_mul31;
				h_rotadd_q <= n_rotadd;
				h_mul17_q  <= n_mul17;
			end
		end
	end

endmodule

// ===== rtl/bf3h_queue.sv =====
`timescale 1ns / 1ps
// short job queue between the hashing front end and the probing back end
module bf3h_queue import bf3h_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t head,
	output logic empty
);

	job_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/bf3h_back.sv =====
`timescale 1ns / 1ps
// back end: clears the store, reduces hashes to indexes, probes and reports
module bf3h_back import bf3h_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [FB_W-1:0] filter_bits,
	input  logic [HC_W-1:0] hash_count,
	input  job_t            head,
	input  logic            q_empty,
	output logic            pop,
	output logic            clearing,
	output logic            out_valid,
	input  logic            out_stall,
	output out_item_t       out_data
);

	localparam int CMP_W = (FB_W > M_W) ? FB_W : M_W;

	back_state_t state_q, state_d;

	logic [IDX_W-1:0]     clr_cnt_q;
	logic                 op_q;
	logic [HASH_W-1:0]    h1_q;
	logic [HASH_W-1:0]    h2_q;
	logic [HASH_W-1:0]    work_q;
	logic [IDX_W-1:0]     rem_q;
	logic [IDX_W-1:0]     rem_c;
	logic [DIG_CNT_W-1:0] dig_q;
	logic [HSEL_W-1:0]    hsel_q;
	logic [IDX_W-1:0]     idx_q [NUM_HASH];
	logic [M_W-1:0]       m_q;
	logic [HC_W-1:0]      cnt_q;
	logic [HC_W-1:0]      probe_q;
	logic [HSEL_W-1:0]    pm_q;
	logic                 found_q;
	logic                 rd_pend_s1;
	logic                 out_valid_q;
	out_item_t            out_q;
	logic                 out_free;
	logic                 mod_last;
	logic                 probe_last;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic             ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic             ram_rdata;
	logic             rd_issue;

	// effective modulus: zero counts as one, large values saturate
	function automatic logic [M_W-1:0] eff_size(input logic [FB_W-1:0] fb);
		logic [CMP_W-1:0] fbx;
		fbx = CMP_W'(fb);
		if (fb == '0) begin
			return M_W'(1);
		end else if (fbx > CMP_W'(MAX_BITS)) begin
			return M_W'(MAX_BITS);
		end else begin
			return M_W'(fbx);
		end
	endfunction

	bf3h_ram #(
		.WIDTH(1),
		.DEPTH(MAX_BITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free   = ~out_valid_q | ~out_stall;
	assign mod_last   = (dig_q == DIG_CNT_W'(DIGITS - 1)) && (hsel_q == HSEL_W'(NUM_HASH - 1));
	assign probe_last = (probe_q == HC_W'(cnt_q - 1'b1));
	assign clearing   = (state_q == ST_CLEAR);
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// remainder step: one digit of restoring reduction
	always_comb begin
		logic [M_W-1:0] r;
		rem_c = rem_q;
		for (int b = 0; b < DIGIT_W; b++) begin
			r = {rem_c, work_q[HASH_W-1-b]};
			if (r >= m_q) begin
				r = r - m_q;
			end
			rem_c = r[IDX_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == IDX_W'(MAX_BITS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (!q_empty) state_d = ST_MOD;
			end
			ST_MOD: begin
				if (mod_last) state_d = (cnt_q == '0) ? ST_DONE : ST_PROBE;
			end
			ST_PROBE: begin
				if (probe_last) state_d = (op_q == OP_QUERY) ? ST_WAIT : ST_DONE;
			end
			ST_WAIT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// store port and queue controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[pm_q];
		ram_wdata = 1'b1;
		ram_raddr = idx_q[pm_q];
		rd_issue  = 1'b0;
		pop       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = 1'b0;
			end
			ST_IDLE: begin
				pop = ~q_empty;
			end
			ST_PROBE: begin
				ram_we   = (op_q == OP_INSERT);
				rd_issue = (op_q == OP_QUERY);
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_issue;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// job datapath
	always_ff @(posedge clk) begin
		if (rd_pend_s1 && !ram_rdata) begin
			found_q <= 1'b0;
		end
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					op_q    <= head.op;
					work_q  <= head.h_mul31;
					h1_q    <= head.h_rotadd;
					h2_q    <= head.h_mul17;
					m_q     <= eff_size(filter_bits);
					cnt_q   <= hash_count;
					rem_q   <= '0;
					dig_q   <= '0;
					hsel_q  <= '0;
					probe_q <= '0;
					pm_q    <= '0;
					found_q <= 1'b1;
				end
			end
			ST_MOD: begin
				if (dig_q == DIG_CNT_W'(DIGITS - 1)) begin
					idx_q[hsel_q] <= rem_c;
					rem_q         <= '0;
					dig_q         <= '0;
					hsel_q        <= hsel_q + 1'b1;
					work_q        <= (hsel_q == '0) ? h1_q : h2_q;
				end else begin
					rem_q  <= rem_c;
					dig_q  <= dig_q + 1'b1;
					work_q <= work_q << DIGIT_W;
				end
			end
			ST_PROBE: begin
				probe_q <= probe_q + 1'b1;
				pm_q    <= (pm_q == HSEL_W'(NUM_HASH - 1)) ? '0 : pm_q + 1'b1;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.done_op <= op_q;
					out_q.found   <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/bloom_filter_three_hash.sv =====
`timescale 1ns / 1ps
// Bloom filter with three running hashes, keys streamed one character a transaction.
// Input channel (in_valid/in_stall/in_data): op, signed key_char and key_last.
// Each character is hashed by the front end; on key_last the three
// hashes and the op go into a two-entry queue and the hashes return to zero.
// The back end takes one key at a time: it takes the key from the queue, then uses
// a shared remainder unit (three 64-bit hashes, one 8-bit digit a cycle) to turn the
// hashes into indexes, then probes the bit store hash_count times; a query also
// waits for its last read before the result register is loaded. Each result appears
// on out_valid/out_stall/out_data (done_op, found).
// The front end keeps taking characters while the back end works or a result
// waits, until the queue fills; a stalled result simply holds its register.
// Configuration: cfg_we writes cfg_wdata into filter_bits (index 0) or
// hash_count (index 1) at once; other indexes are ignored. Write only when idle.
// After reset the bit store is cleared, all 1024 bits at one bit a cycle, during
// which in_stall stays high; registers return to 100 and 3.
module bloom_filter_three_hash import bf3h_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [FB_W-1:0] filter_bits_q;
	logic [HC_W-1:0] hash_count_q;
	logic            push;
	job_t            push_data;
	logic            q_full;
	logic            q_empty;
	logic            pop;
	job_t            head;
	logic            clearing;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= FB_RESET;
			hash_count_q  <= HC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_BITS: filter_bits_q <= cfg_wdata[FB_W-1:0];
				REG_HASH_COUNT:  hash_count_q  <= cfg_wdata[HC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bf3h_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	bf3h_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	bf3h_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.filter_bits (filter_bits_q),
		.hash_count  (hash_count_q),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule
